// ===== hdl/ssieve_pkg.sv =====
// shared constants and types of the segmented prime sieve
`default_nettype none
package ssieve_pkg;

	localparam int VALUE_BITS  = 24;
	localparam int WINDOW_SIZE = 64;
	localparam int BASE_LIMIT  = 4096;
	localparam int INDEX_BITS  = 18;

	localparam int WIN_AW  = $clog2(WINDOW_SIZE);
	localparam int BASE_AW = $clog2(BASE_LIMIT);
	// window start can reach twice the value range
	localparam int WS_W    = VALUE_BITS + 1;
	// base prime counter holds BASE_LIMIT itself
	localparam int P_W     = BASE_AW + 1;
	// square of the base prime counter
	localparam int SQ_W    = 2 * P_W;
	// crossing offset: up to 2p or window size plus p
	localparam int OFF_W   = BASE_AW + 2;
	// remainder unit: four dividend bits per cycle
	localparam int DIV_R   = 4;
	localparam int DIV_STEPS = (WS_W + DIV_R - 1) / DIV_R;
	localparam int DVD_W   = DIV_STEPS * DIV_R;
	localparam int DCNT_W  = $clog2(DIV_STEPS + 1);
	// small sieve index runs up to the square root of BASE_LIMIT
	localparam int BI_W    = BASE_AW / 2 + 2;
	localparam int BJ_W    = BASE_AW + 1;

	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	// register indexes, taken from paddr[2]
	localparam logic REG_LO_BOUND = 1'b0;
	localparam logic REG_HI_BOUND = 1'b1;

	typedef enum logic [11:0] {
		S_FILL  = 12'b0000_0000_0001,
		S_BRD   = 12'b0000_0000_0010,
		S_BCHK  = 12'b0000_0000_0100,
		S_BMARK = 12'b0000_0000_1000,
		S_IDLE  = 12'b0000_0001_0000,
		S_START = 12'b0000_0010_0000,
		S_PRD   = 12'b0000_0100_0000,
		S_PCHK  = 12'b0000_1000_0000,
		S_DIV   = 12'b0001_0000_0000,
		S_OFF   = 12'b0010_0000_0000,
		S_MARK  = 12'b0100_0000_0000,
		S_FIN   = 12'b1000_0000_0000
	} state_t;

endpackage
`default_nettype wire

// ===== hdl/ssieve_if.sv =====
// request and result channel interfaces of the segmented prime sieve
`default_nettype none
interface ssieve_req_if;
	import ssieve_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] window_index;
	modport source (output valid, output window_index, input ready);
	modport sink   (input valid, input window_index, output ready);
endinterface

interface ssieve_rsp_if;
	import ssieve_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [WINDOW_SIZE-1:0] prime_flags;
	logic                   past_range;
	modport source (output valid, output prime_flags, output past_range, input ready);
	modport sink   (input valid, input prime_flags, input past_range, output ready);
endinterface
`default_nettype wire

// ===== hdl/segmented_prime_sieve.sv =====
// segmented prime sieve: base table, window sequencer and shared remainder unit
// After reset the block first fills its 4096-entry base mark memory and sieves it;
// req.ready stays low until then. Each transaction names a 64-number window starting
// at lo_bound + 64*window_index and is sieved on its own: every candidate p from 2 while
// p*p <= hi_bound and p < 4096 is read from the mark memory and checked, and each base prime
// runs the remainder unit (four dividend bits per cycle) and then crosses its multiples in
// the window one by one. A window past the range goes straight to the result. The single
// read port of the mark memory and the shared remainder unit set the pace of this work.
// One window is in work at a time; a finished result waits in the output register while
// the next request may already be accepted.
`default_nettype none
module segmented_prime_sieve (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire [ssieve_pkg::ADDR_W-1:0] paddr,
	input  wire [ssieve_pkg::DATA_W-1:0] pwdata,
	output logic [ssieve_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	ssieve_req_if.sink                  req,
	ssieve_rsp_if.source                rsp
);
	import ssieve_pkg::*;

	state_t state_q;

	logic [VALUE_BITS-1:0]  lo_bound_q;
	logic [VALUE_BITS-1:0]  hi_bound_q;

	logic                   mem [BASE_LIMIT];
	logic                   rd_data_q;
	logic [BASE_AW-1:0]     rd_addr;
	logic                   mem_we;
	logic [BASE_AW-1:0]     mem_wa;
	logic                   mem_wd;

	logic [BJ_W-1:0]        fill_q;
	logic [BI_W-1:0]        bi_q;
	logic [BJ_W-1:0]        bj_q;
	logic [2*BI_W-1:0]      bi_sq;

	logic [WS_W-1:0]        ws_q;
	logic [WINDOW_SIZE-1:0] marks_q;
	logic                   win_past_q;
	logic [P_W-1:0]         p_q;
	logic [SQ_W-1:0]        sq_q;
	logic [DVD_W-1:0]       dvd_q;
	logic [BASE_AW-1:0]     rem_q;
	logic [DCNT_W-1:0]      dcnt_q;
	logic [OFF_W-1:0]       off_q;

	logic                   rsp_valid_q;
	logic [WINDOW_SIZE-1:0] flags_q;
	logic                   past_q;

	logic                   req_fire;
	logic                   cfg_wr;
	logic [WS_W-1:0]        ws_next;
	logic [BASE_AW-1:0]     rem_next;
	logic [OFF_W-1:0]       off_base;
	logic [WS_W:0]          first_mult;
	logic [OFF_W:0]         two_p;
	logic [WS_W-1:0]        win_span;
	logic [WINDOW_SIZE-1:0] init_marks;
	logic [1:0]             low_k;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_HI_BOUND) ? DATA_W'(hi_bound_q)
	                                           : DATA_W'(lo_bound_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_bound_q <= '0;
			hi_bound_q <= '1;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_LO_BOUND) begin
				lo_bound_q <= pwdata[VALUE_BITS-1:0];
			end else begin
				hi_bound_q <= pwdata[VALUE_BITS-1:0];
			end
		end
	end

	// handshakes
	assign req.ready       = (state_q == S_IDLE);
	assign req_fire        = req.valid && req.ready;
	assign rsp.valid       = rsp_valid_q;
	assign rsp.prime_flags = flags_q;
	assign rsp.past_range  = past_q;

	// base mark memory, one write and one registered read port
	assign rd_addr = (state_q == S_BRD) ? BASE_AW'(bi_q) : p_q[BASE_AW-1:0];

	always_comb begin
		mem_we = 1'b0;
		mem_wa = fill_q[BASE_AW-1:0];
		mem_wd = (fill_q >= BJ_W'(2));
		if (state_q == S_FILL) begin
			mem_we = 1'b1;
		end else if (state_q == S_BMARK) begin
			mem_we = 1'b1;
			mem_wa = bj_q[BASE_AW-1:0];
			mem_wd = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign bi_sq = bi_q * bi_q;

	// window start and initial marks for numbers below 2 or above the high bound
	assign ws_next  = WS_W'(lo_bound_q) + (WS_W'(req.window_index) << WIN_AW);
	assign win_span = WS_W'(hi_bound_q) - ws_q;
	assign low_k    = (ws_q < WS_W'(2)) ? (2'd2 - ws_q[1:0]) : 2'd0;

	always_comb begin
		for (int k = 0; k < WINDOW_SIZE; k++) begin
			init_marks[k] = (WIN_AW'(k) >= WIN_AW'(low_k)) &&
			                ((win_span >= WS_W'(WINDOW_SIZE - 1)) ||
			                 (WIN_AW'(k) <= win_span[WIN_AW-1:0]));
		end
	end

	// remainder unit: four restoring steps per cycle
	always_comb begin
		logic [BASE_AW:0] t;
		rem_next = rem_q;
		for (int s = 0; s < DIV_R; s++) begin
			t = {rem_next, dvd_q[DVD_W-1-s]};
			if (t >= {1'b0, p_q[BASE_AW-1:0]}) begin
				t = t - {1'b0, p_q[BASE_AW-1:0]};
			end
			rem_next = t[BASE_AW-1:0];
		end
	end

	// first offset to cross: next multiple, but never below 2p
	assign off_base   = (rem_q == '0) ? '0 : OFF_W'(p_q[BASE_AW-1:0] - rem_q);
	assign first_mult = (WS_W+1)'(ws_q) + (WS_W+1)'(off_base);
	assign two_p      = (OFF_W+1)'({p_q, 1'b0});

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL;
			fill_q      <= '0;
			bi_q        <= BI_W'(2);
			bj_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// a result taken this cycle frees the output unless a new one loads
			if (rsp_valid_q && rsp.ready && (state_q != S_FIN)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_FILL: begin
					fill_q <= fill_q + BJ_W'(1);
					if (fill_q == BJ_W'(BASE_LIMIT - 1)) begin
						state_q <= S_BRD;
					end
				end
				S_BRD: begin
					if (bi_sq >= (2*BI_W)'(BASE_LIMIT)) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_BCHK;
					end
				end
				S_BCHK: begin
					if (rd_data_q) begin
						bj_q    <= BJ_W'(bi_sq);
						state_q <= S_BMARK;
					end else begin
						bi_q    <= bi_q + BI_W'(1);
						state_q <= S_BRD;
					end
				end
				S_BMARK: begin
					bj_q <= bj_q + BJ_W'(bi_q);
					if ((bj_q + BJ_W'(bi_q)) >= BJ_W'(BASE_LIMIT)) begin
						bi_q    <= bi_q + BI_W'(1);
						state_q <= S_BRD;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						ws_q    <= ws_next;
						state_q <= S_START;
					end
				end
				S_START: begin
					p_q  <= P_W'(2);
					sq_q <= SQ_W'(4);
					if (ws_q > WS_W'(hi_bound_q)) begin
						marks_q    <= '0;
						win_past_q <= 1'b1;
						state_q    <= S_FIN;
					end else begin
						marks_q    <= init_marks;
						win_past_q <= 1'b0;
						state_q    <= S_PRD;
					end
				end
				S_PRD: begin
					if (p_q == P_W'(BASE_LIMIT) || sq_q > SQ_W'(hi_bound_q)) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_PCHK;
					end
				end
				S_PCHK: begin
					if (rd_data_q) begin
						dvd_q   <= DVD_W'(ws_q);
						rem_q   <= '0;
						dcnt_q  <= '0;
						state_q <= S_DIV;
					end else begin
						p_q     <= p_q + P_W'(1);
						sq_q    <= sq_q + SQ_W'({p_q, 1'b1});
						state_q <= S_PRD;
					end
				end
				S_DIV: begin
					rem_q  <= rem_next;
					dvd_q  <= dvd_q << DIV_R;
					dcnt_q <= dcnt_q + DCNT_W'(1);
					if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) begin
						state_q <= S_OFF;
					end
				end
				S_OFF: begin
					if (first_mult < (WS_W+1)'(two_p)) begin
						off_q <= OFF_W'(two_p - (OFF_W+1)'(ws_q));
					end else begin
						off_q <= off_base;
					end
					state_q <= S_MARK;
				end
				S_MARK: begin
					if (off_q < OFF_W'(WINDOW_SIZE)) begin
						marks_q[off_q[WIN_AW-1:0]] <= 1'b0;
						off_q <= off_q + OFF_W'(p_q);
					end else begin
						p_q     <= p_q + P_W'(1);
						sq_q    <= sq_q + SQ_W'({p_q, 1'b1});
						state_q <= S_PRD;
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						flags_q     <= marks_q;
						past_q      <= win_past_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> !req.ready)
		else $error("request accepted while a window is in work");

	a_past_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && past_q) |-> (flags_q == '0))
		else $error("window past the range reports primes");

	a_base_done: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (bi_sq >= (2*BI_W)'(BASE_LIMIT)))
		else $error("ready before the base table is sieved");

	a_prime_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PCHK) |-> (p_q < P_W'(BASE_LIMIT)))
		else $error("base prime index out of table");

endmodule
`default_nettype wire

// ===== tb/sv/ssieve_checker.sv =====
// checker for the segmented prime sieve: window predictor and result comparison
`timescale 1ns / 1ps
module ssieve_checker (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire [ssieve_pkg::ADDR_W-1:0]  paddr,
	input  wire [ssieve_pkg::DATA_W-1:0]  pwdata,
	input  wire                           pready,
	ssieve_req_if                         req,
	ssieve_rsp_if                         rsp,
	output int                            errors,
	output int                            outstanding
);
	import ssieve_pkg::*;

	typedef struct {
		logic [WINDOW_SIZE-1:0] prime_flags;
		logic                   past_range;
	} window_result_t;

	window_result_t expected_windows[$];
	int             base_primes[$];
	logic [VALUE_BITS-1:0] start_value;
	logic [VALUE_BITS-1:0] end_value;

	// small sieve for the base primes
	initial begin
		bit composite [BASE_LIMIT];
		for (int i = 2; i < BASE_LIMIT; i++) begin
			if (!composite[i]) begin
				base_primes.push_back(i);
				for (int j = i * i; j < BASE_LIMIT; j += i)
					composite[j] = 1'b1;
			end
		end
	end

	// crossing off one window with the base primes
	function automatic window_result_t sieve_window(logic [INDEX_BITS-1:0] idx);
		window_result_t r;
		longint ws;
		longint m;
		longint n;
		longint p;
		ws = longint'(start_value) + longint'(idx) * WINDOW_SIZE;
		r.prime_flags = '0;
		r.past_range = 1'b0;
		if (ws > longint'(end_value)) begin
			r.past_range = 1'b1;
			return r;
		end
		for (int k = 0; k < WINDOW_SIZE; k++) begin
			n = ws + k;
			r.prime_flags[k] = (n >= 2) && (n <= longint'(end_value));
		end
		foreach (base_primes[i]) begin
			p = base_primes[i];
			if (p * p > longint'(end_value))
				break;
			m = ((ws + p - 1) / p) * p;
			if (m < 2 * p)
				m = 2 * p;
			for (; m < ws + WINDOW_SIZE; m += p)
				r.prime_flags[m - ws] = 1'b0;
		end
		return r;
	endfunction

	// register shadow, prediction on request, comparison on result
	always @(posedge clk or negedge arst_n) begin
		window_result_t want;
		int bad;
		if (!arst_n) begin
			start_value <= '0;
			end_value <= '1;
			errors <= 0;
			outstanding <= 0;
			expected_windows.delete();
		end else begin
			bad = 0;
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_HI_BOUND)
					end_value <= pwdata[VALUE_BITS-1:0];
				else
					start_value <= pwdata[VALUE_BITS-1:0];
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_windows.size() == 0) begin
					$error("result transaction with no window pending");
					bad++;
				end else begin
					want = expected_windows.pop_front();
					if (rsp.prime_flags !== want.prime_flags) begin
						$error("prime_flags: expected %h, actual %h",
							want.prime_flags, rsp.prime_flags);
						bad++;
					end
					if (rsp.past_range !== want.past_range) begin
						$error("past_range: expected %b, actual %b",
							want.past_range, rsp.past_range);
						bad++;
					end
				end
			end
			if (req.valid && req.ready)
				expected_windows.push_back(sieve_window(req.window_index));
			errors <= errors + bad;
			outstanding <= expected_windows.size();
		end
	end
endmodule

// ===== tb/sv/tb_segmented_prime_sieve.sv =====
// top of the segmented prime sieve testbench: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_segmented_prime_sieve;
	import ssieve_pkg::*;

	localparam int CYCLE_LIMIT = 8000000;
	localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	int                errors;
	int                outstanding;
	int                snd_idle;
	int                rcv_idle;
	int                windows_sent;
	int                settings_used;
	int                cycles;
	logic [VALUE_BITS-1:0] cur_start;
	logic [VALUE_BITS-1:0] cur_end;

	ssieve_req_if req_ch();
	ssieve_rsp_if rsp_ch();

	segmented_prime_sieve uut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req(req_ch), .rsp(rsp_ch)
	);

	ssieve_checker chk (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .pready(pready),
		.req(req_ch), .rsp(rsp_ch), .errors(errors), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side stalls
	initial rsp_ch.ready = 1'b0;
	always @(negedge clk)
		rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);

	// one register write, setup then access
	task automatic write_reg(logic reg_idx, logic [VALUE_BITS-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_range(logic [VALUE_BITS-1:0] s, logic [VALUE_BITS-1:0] e);
		write_reg(REG_LO_BOUND, s);
		write_reg(REG_HI_BOUND, e);
		cur_start = s;
		cur_end = e;
		settings_used++;
	endtask

	// one window request transaction, called and returning at a falling edge
	task automatic send_window(logic [INDEX_BITS-1:0] idx);
		while ($urandom_range(0, 99) < snd_idle) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.window_index <= idx;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		windows_sent++;
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// random range settings with windows mostly inside the range
	task automatic random_group(int count);
		logic [VALUE_BITS-1:0] s;
		logic [VALUE_BITS-1:0] e;
		longint span;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			s = VALUE_BITS'($urandom_range(0, 60000));
			e = s + VALUE_BITS'($urandom_range(0, 8000));
		end else if (pick < 93) begin
			s = VALUE_BITS'($urandom);
			e = (longint'(s) + 3000 > longint'(VALUE_MAX)) ? VALUE_MAX
			                                              : s + VALUE_BITS'($urandom_range(0, 3000));
		end else begin
			s = VALUE_BITS'($urandom_range(100, 60000));
			e = VALUE_BITS'($urandom_range(0, s - 1));
		end
		set_range(s, e);
		span = (e >= s) ? (longint'(e) - longint'(s)) / WINDOW_SIZE + 1 : 0;
		if (span > (1 << INDEX_BITS) - 1)
			span = (1 << INDEX_BITS) - 1;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 85)
				send_window(INDEX_BITS'($urandom_range(0, int'(span))));
			else
				send_window(INDEX_BITS'($urandom));
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.window_index = '0;
		snd_idle = 0;
		rcv_idle = 0;
		windows_sent = 0;
		settings_used = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: defaults, full range at both ends
		send_window('0);
		send_window('1);
		drain();
		set_range(VALUE_MAX, VALUE_MAX);
		send_window('0);
		send_window(1);
		send_window('1);
		drain();
		// start above end: every window past the range
		set_range(100, 50);
		send_window(0);
		send_window(5);
		drain();
		// empty range holding only zero
		set_range('0, '0);
		send_window(0);
		send_window(1);
		drain();
		// small range with a window cut by the end
		set_range('0, 1000);
		for (int i = 0; i < 4; i++)
			send_window(INDEX_BITS'(i));
		send_window(15);
		send_window(16);
		send_window('1);
		drain();
		set_range(24'hAAAAAA, 24'hAAAAAA + 24'd200);
		send_window(0);
		send_window(3);
		send_window(18'h2AAAA);
		drain();

		// random part under three idling patterns
		for (int mode = 0; mode < 3; mode++) begin
			snd_idle = (mode == 0) ? 16 : (mode == 1) ? 48 : 0;
			rcv_idle = (mode == 0) ? 48 : (mode == 1) ? 16 : 0;
			for (int g = 0; g < 4; g++)
				random_group(10);
		end

		drain();
		repeat (50) @(negedge clk);
		$display("covered %0d windows under %0d range settings", windows_sent, settings_used);
		$display("including past-range, partial and full-width windows");
		if (errors == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// ===== segmented_prime_sieve.f =====
hdl/ssieve_pkg.sv
hdl/ssieve_if.sv
hdl/segmented_prime_sieve.sv
tb/sv/ssieve_checker.sv
tb/sv/tb_segmented_prime_sieve.sv
